// ===== design/gfd_pkg.sv =====
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared types and fixed widths of the grid field direction block.
// ----------------------------------------------------------------------------
`default_nettype none

package gfd_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;
    localparam int SPACING_W  = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEIGHT  = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_SPACING = 2'd2
    } cfg_reg_t;

    localparam logic [CFG_DATA_W-1:0] HEIGHT_MIN = 11'd2;
    localparam logic [CFG_DATA_W-1:0] HEIGHT_MAX = 11'd1024;

    // payload widths
    localparam int SAMPLE_W = 16;
    localparam int ROW_W    = 10;
    localparam int CELL_W   = 10;
    localparam int FIELD_W  = 18;
    localparam int UNIT_W   = 16;

    // datapath widths
    localparam int SUM_W    = 18;   // a and b
    localparam int MAG_W    = 17;   // |a| and |b|
    localparam int DIVR_W   = 9;    // twice the spacing
    localparam int SQ_W     = 34;   // |a|^2
    localparam int REM_W    = 35;   // partial remainder, also holds a^2 + b^2
    localparam int ACC_W    = 36;   // remainder after one shift
    localparam int WORK_W   = 30;   // dividend / quotient / radicand shifter
    localparam int ROOT_W   = 15;   // unit magnitude, up to 2^14

    // step counts of the shared shift-subtract unit
    localparam int STEP_W       = 5;
    localparam int FDIV_STEPS   = 17;
    localparam int UDIV_STEPS   = 29;
    localparam int SQRT_STEPS   = 15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FDIV,
        ST_SQA,
        ST_SQB,
        ST_NSUM,
        ST_UDIV,
        ST_USQRT,
        ST_DONE
    } state_t;

endpackage

`default_nettype wire

// ===== design/grid_field_direction.sv =====
// ----------------------------------------------------------------------------
// grid_field_direction
// A sample that closes no decimated cell is taken back to back with the next.
// A sample that closes a decimated cell holds the input while the shared
// shift-subtract unit runs the two field divisions and, after the squares,
// the unit divisions and square roots; a zero vector stops after the field
// divisions. The result then sits in an output register while input resumes.
// Reset clears counters, taps, sequencer state and handshake and sets the
// settings to defaults; datapath, output data and line buffer are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module grid_field_direction #(
    parameter int MAX_WIDTH = 1024,
    parameter int DECIMATE  = 3
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic        [gfd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic        [gfd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic signed [gfd_pkg::SAMPLE_W-1:0]   potential,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic             [gfd_pkg::CELL_W-1:0]     cell_row,
    output logic             [gfd_pkg::CELL_W-1:0]     cell_col,
    output logic signed      [gfd_pkg::FIELD_W-1:0]    field_x,
    output logic signed      [gfd_pkg::FIELD_W-1:0]    field_y,
    output logic signed      [gfd_pkg::UNIT_W-1:0]     unit_x,
    output logic signed      [gfd_pkg::UNIT_W-1:0]     unit_y,
    output logic                                       zero_vector
);

    import gfd_pkg::*;

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int LW  = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (LW > CFG_DATA_W) ? LW : CFG_DATA_W;
    localparam int CXW = (AW > CELL_W) ? AW : CELL_W;
    localparam int PW  = (DECIMATE > 1) ? $clog2(DECIMATE) : 1;
    localparam logic [PW-1:0] PH_LAST = PW'(DECIMATE - 1);

    // control state
    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic                      comp_reg, comp_next;
    logic [CFG_DATA_W-1:0]     grid_height_reg, grid_height_next;
    logic [CFG_DATA_W-1:0]     grid_width_reg, grid_width_next;
    logic [SPACING_W-1:0]      spacing_reg, spacing_next;
    logic [ROW_W-1:0]          row_count_reg, row_count_next;
    logic [AW-1:0]             col_count_reg, col_count_next;
    logic [PW-1:0]             row_ph_reg, row_ph_next;
    logic [PW-1:0]             col_ph_reg, col_ph_next;
    logic signed [SAMPLE_W-1:0] upper_left_reg, upper_left_next;
    logic signed [SAMPLE_W-1:0] left_sample_reg, left_sample_next;
    logic                      out_valid_reg, out_valid_next;

    // working registers
    logic [CELL_W-1:0]         wrow_reg, wrow_next;
    logic [CELL_W-1:0]         wcol_reg, wcol_next;
    logic                      neg_a_reg, neg_a_next;
    logic                      neg_b_reg, neg_b_next;
    logic                      zero_w_reg, zero_w_next;
    logic [MAG_W-1:0]          mag_a_reg, mag_a_next;
    logic [MAG_W-1:0]          mag_b_reg, mag_b_next;
    logic [DIVR_W-1:0]         div_reg, div_next;
    logic [MAG_W-1:0]          fx_reg, fx_next;
    logic [MAG_W-1:0]          fy_reg, fy_next;
    logic [ROOT_W-1:0]         ux_reg, ux_next;
    logic [ROOT_W-1:0]         uy_reg, uy_next;
    logic [SQ_W-1:0]           sq_a_reg, sq_a_next;
    logic [SQ_W-1:0]           sq_b_reg, sq_b_next;
    logic [REM_W-1:0]          n_reg, n_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [WORK_W-1:0]         work_reg, work_next;
    logic [ROOT_W-1:0]         root_reg, root_next;

    // output registers
    logic [CELL_W-1:0]         cell_row_reg, cell_row_next;
    logic [CELL_W-1:0]         cell_col_reg, cell_col_next;
    logic signed [FIELD_W-1:0] field_x_reg, field_x_next;
    logic signed [FIELD_W-1:0] field_y_reg, field_y_next;
    logic signed [UNIT_W-1:0]  unit_x_reg, unit_x_next;
    logic signed [UNIT_W-1:0]  unit_y_reg, unit_y_next;
    logic                      zero_vector_reg, zero_vector_next;

    // control signals
    logic                      in_accept;
    logic                      out_load;
    logic                      step_last;
    logic                      cfg_hit;

    // geometry
    logic [CW-1:0]             eff_w;
    logic [CW-1:0]             gw_ext;
    logic [CW-1:0]             col_inc;
    logic                      col_wrap;
    logic [AW-1:0]             col_adv;
    logic [CFG_DATA_W-1:0]     eff_h;
    logic [CFG_DATA_W-1:0]     row_inc;
    logic                      row_wrap;
    logic                      emit;
    logic [CXW-1:0]            col_m1;

    // cell arithmetic
    logic [SAMPLE_W-1:0]       ram_rdata;
    logic [AW-1:0]             ram_raddr;
    logic signed [SAMPLE_W-1:0] up_sample;
    logic signed [SUM_W-1:0]   a_sum;
    logic signed [SUM_W-1:0]   b_sum;

    // shared shift-subtract unit and multiplier
    logic [ACC_W-1:0]          unit_acc;
    logic [ACC_W-1:0]          unit_opnd;
    logic [ACC_W-1:0]          unit_diff;
    logic                      unit_ge;
    logic [REM_W-1:0]          unit_rem;
    logic [WORK_W-1:0]         quo_shift;
    logic [ROOT_W-1:0]         root_shift;
    logic [MAG_W-1:0]          mult_in;
    logic [SQ_W-1:0]           mult_out;

    // ------------------------------------------------------------------
    // line buffer
    // ------------------------------------------------------------------
    gfd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .clk   (clk),
        .we    (in_accept),
        .waddr (col_count_reg),
        .wdata (potential),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // read ahead at the column of the next request so the upper sample is ready
    assign ram_raddr = in_accept ? col_adv : col_count_reg;
    assign up_sample = $signed(ram_rdata);

    // ------------------------------------------------------------------
    // geometry and counters
    // ------------------------------------------------------------------
    always_comb
    begin
        gw_ext = CW'(grid_width_reg);
        if (gw_ext < CW'(2))
        begin
            eff_w = CW'(2);
        end
        else if (gw_ext > CW'(MAX_WIDTH))
        begin
            eff_w = CW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = gw_ext;
        end

        if (grid_height_reg < HEIGHT_MIN)
        begin
            eff_h = HEIGHT_MIN;
        end
        else if (grid_height_reg > HEIGHT_MAX)
        begin
            eff_h = HEIGHT_MAX;
        end
        else
        begin
            eff_h = grid_height_reg;
        end
    end

    assign col_inc  = CW'(col_count_reg) + CW'(1);
    assign col_wrap = (col_inc >= eff_w);
    assign col_adv  = col_wrap ? '0 : col_inc[AW-1:0];
    assign row_inc  = CFG_DATA_W'(row_count_reg) + CFG_DATA_W'(1);
    assign row_wrap = (row_inc >= eff_h);
    assign emit     = (row_count_reg != '0) && (col_count_reg != '0) &&
                      (row_ph_reg == '0) && (col_ph_reg == '0);
    assign col_m1   = CXW'(col_count_reg) - CXW'(1);

    always_comb
    begin
        cfg_hit = 1'b0;
        unique case (cfg_index)
            REG_HEIGHT,
            REG_WIDTH,
            REG_SPACING: cfg_hit = 1'b1;
            default:     cfg_hit = 1'b0;
        endcase
    end

    always_comb
    begin
        grid_height_next = grid_height_reg;
        grid_width_next  = grid_width_reg;
        spacing_next     = spacing_reg;
        row_count_next   = row_count_reg;
        col_count_next   = col_count_reg;
        row_ph_next      = row_ph_reg;
        col_ph_next      = col_ph_reg;
        upper_left_next  = upper_left_reg;
        left_sample_next = left_sample_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HEIGHT:  grid_height_next = cfg_data;
                REG_WIDTH:   grid_width_next  = cfg_data;
                REG_SPACING: spacing_next     = cfg_data[SPACING_W-1:0];
                default:     ;
            endcase
        end

        if (cfg_we && cfg_hit)
        begin
            // any register write restarts the frame
            row_count_next = '0;
            col_count_next = '0;
            row_ph_next    = PH_LAST;
            col_ph_next    = PH_LAST;
        end
        else if (in_accept)
        begin
            upper_left_next  = up_sample;
            left_sample_next = potential;
            col_count_next   = col_adv;
            if (col_wrap)
            begin
                col_ph_next = PH_LAST;
                if (row_wrap)
                begin
                    row_count_next = '0;
                    row_ph_next    = PH_LAST;
                end
                else
                begin
                    row_count_next = row_inc[ROW_W-1:0];
                    row_ph_next    = (row_ph_reg == PH_LAST) ? '0 : row_ph_reg + PW'(1);
                end
            end
            else
            begin
                col_ph_next = (col_ph_reg == PH_LAST) ? '0 : col_ph_reg + PW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && emit)
                begin
                    state_next = ST_FDIV;
                end
            end
            ST_FDIV:
            begin
                if (step_last && comp_reg)
                begin
                    state_next = zero_w_reg ? ST_DONE : ST_SQA;
                end
            end
            ST_SQA:  state_next = ST_SQB;
            ST_SQB:  state_next = ST_NSUM;
            ST_NSUM: state_next = ST_UDIV;
            ST_UDIV:
            begin
                if (step_last)
                begin
                    state_next = ST_USQRT;
                end
            end
            ST_USQRT:
            begin
                if (step_last)
                begin
                    state_next = comp_reg ? ST_DONE : ST_UDIV;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ST_IDLE);
        in_accept = in_valid && in_ready;
        out_load  = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
        unique case (state_reg)
            ST_FDIV:  step_last = (step_reg == STEP_W'(FDIV_STEPS - 1));
            ST_UDIV:  step_last = (step_reg == STEP_W'(UDIV_STEPS - 1));
            ST_USQRT: step_last = (step_reg == STEP_W'(SQRT_STEPS - 1));
            default:  step_last = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // shared shift-subtract unit and square multiplier
    // ------------------------------------------------------------------
    always_comb
    begin
        unique case (state_reg)
            ST_FDIV:
            begin
                unit_acc  = {rem_reg, work_reg[WORK_W-1]};
                unit_opnd = ACC_W'(div_reg);
            end
            ST_UDIV:
            begin
                unit_acc  = {rem_reg, work_reg[WORK_W-1]};
                unit_opnd = ACC_W'(n_reg);
            end
            ST_USQRT:
            begin
                // bring down two radicand bits, trial is 4*root + 1
                unit_acc  = {rem_reg[REM_W-2:0], work_reg[WORK_W-1 -: 2]};
                unit_opnd = ACC_W'({root_reg, 2'b01});
            end
            default:
            begin
                unit_acc  = '0;
                unit_opnd = '0;
            end
        endcase
        unit_ge    = (unit_acc >= unit_opnd);
        unit_diff  = unit_acc - unit_opnd;
        unit_rem   = unit_ge ? unit_diff[REM_W-1:0] : unit_acc[REM_W-1:0];
        quo_shift  = {work_reg[WORK_W-2:0], unit_ge};
        root_shift = {root_reg[ROOT_W-2:0], unit_ge};
    end

    assign mult_in  = (state_reg == ST_SQB) ? mag_b_reg : mag_a_reg;
    assign mult_out = SQ_W'(mult_in) * SQ_W'(mult_in);

    // ------------------------------------------------------------------
    // datapath
    // ------------------------------------------------------------------
    assign a_sum = SUM_W'(upper_left_reg) + SUM_W'(up_sample)
                 - SUM_W'(left_sample_reg) - SUM_W'(potential);
    assign b_sum = SUM_W'(upper_left_reg) + SUM_W'(left_sample_reg)
                 - SUM_W'(up_sample) - SUM_W'(potential);

    always_comb
    begin
        step_next   = step_reg;
        comp_next   = comp_reg;
        wrow_next   = wrow_reg;
        wcol_next   = wcol_reg;
        neg_a_next  = neg_a_reg;
        neg_b_next  = neg_b_reg;
        zero_w_next = zero_w_reg;
        mag_a_next  = mag_a_reg;
        mag_b_next  = mag_b_reg;
        div_next    = div_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        ux_next     = ux_reg;
        uy_next     = uy_reg;
        sq_a_next   = sq_a_reg;
        sq_b_next   = sq_b_reg;
        n_next      = n_reg;
        rem_next    = rem_reg;
        work_next   = work_reg;
        root_next   = root_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && emit)
                begin
                    wrow_next   = row_count_reg - ROW_W'(1);
                    wcol_next   = col_m1[CELL_W-1:0];
                    neg_a_next  = a_sum[SUM_W-1];
                    neg_b_next  = b_sum[SUM_W-1];
                    zero_w_next = (a_sum == '0) && (b_sum == '0);
                    mag_a_next  = a_sum[SUM_W-1] ? MAG_W'(-a_sum) : MAG_W'(a_sum);
                    mag_b_next  = b_sum[SUM_W-1] ? MAG_W'(-b_sum) : MAG_W'(b_sum);
                    div_next    = (spacing_reg == '0) ? DIVR_W'(2) : {spacing_reg, 1'b0};
                    rem_next    = '0;
                    work_next   = {a_sum[SUM_W-1] ? MAG_W'(-a_sum) : MAG_W'(a_sum),
                                   (WORK_W - MAG_W)'(0)};
                    step_next   = '0;
                    comp_next   = 1'b0;
                end
            end
            ST_FDIV:
            begin
                rem_next  = unit_rem;
                work_next = quo_shift;
                step_next = step_reg + STEP_W'(1);
                if (step_last)
                begin
                    step_next = '0;
                    if (!comp_reg)
                    begin
                        fx_next   = quo_shift[MAG_W-1:0];
                        rem_next  = '0;
                        work_next = {mag_b_reg, (WORK_W - MAG_W)'(0)};
                        comp_next = 1'b1;
                    end
                    else
                    begin
                        fy_next   = quo_shift[MAG_W-1:0];
                        comp_next = 1'b0;
                    end
                end
            end
            ST_SQA:
            begin
                sq_a_next = mult_out;
            end
            ST_SQB:
            begin
                sq_b_next = mult_out;
            end
            ST_NSUM:
            begin
                // quotient of (|a|^2 << 28) / n fits 29 bits, so start part way in
                n_next    = REM_W'(sq_a_reg) + REM_W'(sq_b_reg);
                rem_next  = REM_W'(sq_a_reg[SQ_W-1:1]);
                work_next = {sq_a_reg[0], (WORK_W - 1)'(0)};
                step_next = '0;
            end
            ST_UDIV:
            begin
                rem_next  = unit_rem;
                work_next = quo_shift;
                step_next = step_reg + STEP_W'(1);
                if (step_last)
                begin
                    // radicand for the square root
                    rem_next  = '0;
                    root_next = '0;
                    work_next = {1'b0, quo_shift[WORK_W-2:0]};
                    step_next = '0;
                end
            end
            ST_USQRT:
            begin
                rem_next  = unit_rem;
                root_next = root_shift;
                work_next = {work_reg[WORK_W-3:0], 2'b00};
                step_next = step_reg + STEP_W'(1);
                if (step_last)
                begin
                    step_next = '0;
                    if (!comp_reg)
                    begin
                        ux_next   = root_shift;
                        rem_next  = REM_W'(sq_b_reg[SQ_W-1:1]);
                        work_next = {sq_b_reg[0], (WORK_W - 1)'(0)};
                        comp_next = 1'b1;
                    end
                    else
                    begin
                        uy_next   = root_shift;
                        comp_next = 1'b0;
                    end
                end
            end
            ST_DONE: ;
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_comb
    begin
        cell_row_next    = wrow_reg;
        cell_col_next    = wcol_reg;
        field_x_next     = neg_a_reg ? -FIELD_W'({1'b0, fx_reg}) : FIELD_W'({1'b0, fx_reg});
        field_y_next     = neg_b_reg ? -FIELD_W'({1'b0, fy_reg}) : FIELD_W'({1'b0, fy_reg});
        unit_x_next      = zero_w_reg ? '0 :
                           (neg_a_reg ? -UNIT_W'(ux_reg) : UNIT_W'(ux_reg));
        unit_y_next      = zero_w_reg ? '0 :
                           (neg_b_reg ? -UNIT_W'(uy_reg) : UNIT_W'(uy_reg));
        zero_vector_next = zero_w_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            comp_reg        <= 1'b0;
            grid_height_reg <= HEIGHT_MIN;
            grid_width_reg  <= CFG_DATA_W'(2);
            spacing_reg     <= SPACING_W'(1);
            row_count_reg   <= '0;
            col_count_reg   <= '0;
            row_ph_reg      <= PH_LAST;
            col_ph_reg      <= PH_LAST;
            upper_left_reg  <= '0;
            left_sample_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            comp_reg        <= comp_next;
            grid_height_reg <= grid_height_next;
            grid_width_reg  <= grid_width_next;
            spacing_reg     <= spacing_next;
            row_count_reg   <= row_count_next;
            col_count_reg   <= col_count_next;
            row_ph_reg      <= row_ph_next;
            col_ph_reg      <= col_ph_next;
            upper_left_reg  <= upper_left_next;
            left_sample_reg <= left_sample_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wrow_reg   <= wrow_next;
        wcol_reg   <= wcol_next;
        neg_a_reg  <= neg_a_next;
        neg_b_reg  <= neg_b_next;
        zero_w_reg <= zero_w_next;
        mag_a_reg  <= mag_a_next;
        mag_b_reg  <= mag_b_next;
        div_reg    <= div_next;
        fx_reg     <= fx_next;
        fy_reg     <= fy_next;
        ux_reg     <= ux_next;
        uy_reg     <= uy_next;
        sq_a_reg   <= sq_a_next;
        sq_b_reg   <= sq_b_next;
        n_reg      <= n_next;
        rem_reg    <= rem_next;
        work_reg   <= work_next;
        root_reg   <= root_next;
        if (out_load)
        begin
            cell_row_reg    <= cell_row_next;
            cell_col_reg    <= cell_col_next;
            field_x_reg     <= field_x_next;
            field_y_reg     <= field_y_next;
            unit_x_reg      <= unit_x_next;
            unit_y_reg      <= unit_y_next;
            zero_vector_reg <= zero_vector_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign cell_row    = cell_row_reg;
    assign cell_col    = cell_col_reg;
    assign field_x     = field_x_reg;
    assign field_y     = field_y_reg;
    assign unit_x      = unit_x_reg;
    assign unit_y      = unit_y_reg;
    assign zero_vector = zero_vector_reg;

endmodule

`default_nettype wire

// ===== design/gfd_ram.sv =====
// ----------------------------------------------------------------------------
// gfd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/gfd_checker.sv =====
// ----------------------------------------------------------------------------
// gfd_checker
// Port-level checks of the grid field direction block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module gfd_checker (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                out_valid,
    input  wire logic                                out_ready,
    input  wire logic        [gfd_pkg::CELL_W-1:0]   cell_row,
    input  wire logic        [gfd_pkg::CELL_W-1:0]   cell_col,
    input  wire logic signed [gfd_pkg::FIELD_W-1:0]  field_x,
    input  wire logic signed [gfd_pkg::FIELD_W-1:0]  field_y,
    input  wire logic signed [gfd_pkg::UNIT_W-1:0]   unit_x,
    input  wire logic signed [gfd_pkg::UNIT_W-1:0]   unit_y,
    input  wire logic                                zero_vector
);

    // a stalled result stays valid and holds its cell, field_x and unit components
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_row) && $stable(cell_col) &&
            $stable(field_x) && $stable(unit_x) && $stable(unit_y))
    else $error("stalled result changed");

    // zero vector gives zero field and zero direction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && zero_vector |->
            unit_x == '0 && unit_y == '0 && field_x == '0 && field_y == '0)
    else $error("zero vector with nonzero outputs");

    // a nonzero vector always has some direction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !zero_vector |-> unit_x != '0 || unit_y != '0)
    else $error("nonzero vector with zero direction");

    // unit components stay within plus or minus one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> unit_x <= 16'sd16384 && unit_x >= -16'sd16384 &&
            unit_y <= 16'sd16384 && unit_y >= -16'sd16384)
    else $error("unit component out of range");

endmodule

bind grid_field_direction gfd_checker u_gfd_checker (.*);

`default_nettype wire

// ===== dv/grid_field_direction_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grid_field_direction_tb
// Self-checking bench for the potential-grid field and direction block. A
// scoreboard class keeps its own line buffer and frame counters, computes the
// decimated cell results from every accepted sample and checks each result
// request in order. Stimulus is a directed set of 2x2 frames on the reset
// settings, the register extremes, then random settings and sample patterns
// with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------

module grid_field_direction_tb;

    import gfd_pkg::*;

    localparam int      MAX_WIDTH    = 1024;
    localparam int      DECIMATE     = 3;
    localparam int      HALF_PERIOD  = 5;
    localparam int      DRAIN_CYCLES = 160;
    localparam int      RANDOM_ITEMS = 1250;
    localparam int      MAX_PRINTED  = 30;
    localparam longint  TIMEOUT_NS   = 60_000_000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

    // 2x2 frames on the reset settings, one cell each
    localparam logic signed [SAMPLE_W-1:0] DIRECTED [24] = '{
        S_MAX, S_MAX, S_MIN, S_MIN,     // largest positive a
        S_MIN, S_MIN, S_MAX, S_MAX,     // largest negative a
        S_MAX, S_MIN, S_MAX, S_MIN,     // largest b, a zero
        16'sd5, 16'sd5, 16'sd5, 16'sd5, // flat, zero vector
        16'sd7, -16'sd3, -16'sd3, 16'sd7, // checker, zero vector
        -16'sd1, 16'sd0, 16'sd0, 16'sd0 // field truncates toward zero
    };

    typedef enum {
        PAT_RANDOM,
        PAT_SMALL,
        PAT_EXTREME,
        PAT_FLAT,
        PAT_CHECKER,
        PAT_COLUMN,
        PAT_ROW,
        PAT_DIRECT
    } pattern_t;

    typedef enum {
        RX_OPEN,
        RX_COIN,
        RX_HOLD
    } rx_mode_t;

    typedef struct packed {
        logic        [CELL_W-1:0]  row;
        logic        [CELL_W-1:0]  col;
        logic signed [FIELD_W-1:0] fx;
        logic signed [FIELD_W-1:0] fy;
        logic signed [UNIT_W-1:0]  ux;
        logic signed [UNIT_W-1:0]  uy;
        logic                      zero;
    } cell_t;

    class cell_scoreboard;
        logic [CFG_DATA_W-1:0]      height_reg;
        logic [CFG_DATA_W-1:0]      width_reg;
        logic [SPACING_W-1:0]       spacing_reg;
        logic signed [SAMPLE_W-1:0] line_buf [MAX_WIDTH];
        logic signed [SAMPLE_W-1:0] upper_left;
        logic signed [SAMPLE_W-1:0] left_sample;
        int unsigned                row_cnt;
        int unsigned                col_cnt;
        cell_t                      expected_cells [$];
        int                         mismatches;
        int                         cells_checked;
        int                         zero_cells;

        function new();
            height_reg = HEIGHT_MIN;
            width_reg = 11'd2;
            spacing_reg = 8'd1;
            foreach (line_buf[i])
                line_buf[i] = '0;
            upper_left = '0;
            left_sample = '0;
            row_cnt = 0;
            col_cnt = 0;
            mismatches = 0;
            cells_checked = 0;
            zero_cells = 0;
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_HEIGHT:  height_reg = data;
                REG_WIDTH:   width_reg = data;
                REG_SPACING: spacing_reg = data[SPACING_W-1:0];
                default:     return;
            endcase
            // any real register write restarts the frame
            row_cnt = 0;
            col_cnt = 0;
        endfunction

        function int unsigned eff_height();
            if (height_reg < HEIGHT_MIN)
                return HEIGHT_MIN;
            if (height_reg > HEIGHT_MAX)
                return HEIGHT_MAX;
            return height_reg;
        endfunction

        function int unsigned eff_width();
            if (width_reg < 2)
                return 2;
            if (width_reg > MAX_WIDTH)
                return MAX_WIDTH;
            return width_reg;
        endfunction

        // largest m with m^2 * n <= p^2 * 2^28, bit by bit from the top
        function longint unsigned unit_mag(longint unsigned p, longint unsigned n);
            longint unsigned rhs;
            longint unsigned m;
            longint unsigned t;
            rhs = (p * p) << 28;
            m = 0;
            for (int k = 14; k >= 0; k--) begin
                t = m | (64'd1 << k);
                if (t * t * n <= rhs)
                    m = t;
            end
            return m;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] cur);
            int unsigned                w;
            int unsigned                h;
            int unsigned                row;
            int unsigned                col;
            logic signed [SAMPLE_W-1:0] up;
            longint                     a;
            longint                     b;
            longint                     d;
            longint unsigned            pa;
            longint unsigned            pb;
            longint unsigned            n;
            cell_t                      res;
            w = eff_width();
            h = eff_height();
            row = row_cnt;
            col = col_cnt;
            if (col >= w)
                col = w - 1;
            if (row >= h)
                row = h - 1;
            up = line_buf[col % MAX_WIDTH];

            if (row >= 1 && col >= 1 && (row - 1) % DECIMATE == 0 &&
                (col - 1) % DECIMATE == 0)
            begin
                a = longint'(upper_left) + longint'(up) - longint'(left_sample)
                    - longint'(cur);
                b = longint'(upper_left) + longint'(left_sample) - longint'(up)
                    - longint'(cur);
                d = (spacing_reg == 0) ? 2 : 2 * longint'(spacing_reg);
                res.row = CELL_W'(row - 1);
                res.col = CELL_W'(col - 1);
                res.fx = FIELD_W'(a / d);
                res.fy = FIELD_W'(b / d);
                res.zero = (a == 0 && b == 0);
                res.ux = '0;
                res.uy = '0;
                if (!res.zero) begin
                    pa = (a < 0) ? longint'(-a) : longint'(a);
                    pb = (b < 0) ? longint'(-b) : longint'(b);
                    while (pa >= (64'd1 << MAG_W) || pb >= (64'd1 << MAG_W)) begin
                        pa = pa >> 1;
                        pb = pb >> 1;
                    end
                    n = pa * pa + pb * pb;
                    res.ux = UNIT_W'(unit_mag(pa, n));
                    res.uy = UNIT_W'(unit_mag(pb, n));
                    if (a < 0)
                        res.ux = -res.ux;
                    if (b < 0)
                        res.uy = -res.uy;
                end
                expected_cells.push_back(res);
            end

            upper_left = up;
            left_sample = cur;
            line_buf[col % MAX_WIDTH] = cur;
            if (col + 1 >= w) begin
                col_cnt = 0;
                row_cnt = (row + 1 >= h) ? 0 : row + 1;
            end
            else begin
                col_cnt = col + 1;
                row_cnt = row;
            end
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_cell(cell_t got);
            cell_t want;
            if (expected_cells.size() == 0) begin
                report($sformatf("unexpected cell row %0d col %0d", got.row, got.col));
                return;
            end
            want = expected_cells.pop_front();
            cells_checked++;
            if (got.zero === 1'b1)
                zero_cells++;
            if (got.row !== want.row)
                report($sformatf("cell_row got %0d want %0d", got.row, want.row));
            if (got.col !== want.col)
                report($sformatf("cell_col got %0d want %0d", got.col, want.col));
            if (got.fx !== want.fx)
                report($sformatf("field_x at (%0d,%0d) got %0d want %0d",
                                 want.row, want.col, got.fx, want.fx));
            if (got.fy !== want.fy)
                report($sformatf("field_y at (%0d,%0d) got %0d want %0d",
                                 want.row, want.col, got.fy, want.fy));
            if (got.ux !== want.ux)
                report($sformatf("unit_x at (%0d,%0d) got %0d want %0d",
                                 want.row, want.col, got.ux, want.ux));
            if (got.uy !== want.uy)
                report($sformatf("unit_y at (%0d,%0d) got %0d want %0d",
                                 want.row, want.col, got.uy, want.uy));
            if (got.zero !== want.zero)
                report($sformatf("zero_vector at (%0d,%0d) got %0b want %0b",
                                 want.row, want.col, got.zero, want.zero));
        endtask
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        cfg_we = 1'b0;
    logic        [CFG_IDX_W-1:0] cfg_index = '0;
    logic       [CFG_DATA_W-1:0] cfg_data = '0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed  [SAMPLE_W-1:0] potential = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic           [CELL_W-1:0] cell_row;
    logic           [CELL_W-1:0] cell_col;
    logic signed   [FIELD_W-1:0] field_x;
    logic signed   [FIELD_W-1:0] field_y;
    logic signed    [UNIT_W-1:0] unit_x;
    logic signed    [UNIT_W-1:0] unit_y;
    logic                        zero_vector;

    cell_scoreboard              sb;
    logic signed  [SAMPLE_W-1:0] k1;
    logic signed  [SAMPLE_W-1:0] k2;
    int unsigned                 samples_sent = 0;
    int unsigned                 settings_used = 0;
    rx_mode_t                    rx_mode = RX_OPEN;
    int unsigned                 rx_left = 0;

    grid_field_direction #(
        .MAX_WIDTH (MAX_WIDTH),
        .DECIMATE  (DECIMATE)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .potential   (potential),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .cell_row    (cell_row),
        .cell_col    (cell_col),
        .field_x     (field_x),
        .field_y     (field_y),
        .unit_x      (unit_x),
        .unit_y      (unit_y),
        .zero_vector (zero_vector)
    );

    always #HALF_PERIOD clk = ~clk;

    // register writes, accepted samples and result requests, seen at the edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_we)
                sb.apply_reg(cfg_index, cfg_data);
            if (in_valid && in_ready)
                sb.note_sample(potential);
            if (out_valid && out_ready)
                sb.check_cell('{cell_row, cell_col, field_x, field_y, unit_x, unit_y,
                                zero_vector});
        end
    end

    // receiver: stretches of open, coin-flip and held-off ready
    always @(negedge clk) begin
        if (rx_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    rx_mode = RX_OPEN;
                    rx_left = $urandom_range(1, 60);
                end
                5, 6, 7: begin
                    rx_mode = RX_COIN;
                    rx_left = $urandom_range(4, 40);
                end
                default: begin
                    rx_mode = RX_HOLD;
                    rx_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                          : $urandom_range(1, 10);
                end
            endcase
        end
        else
            rx_left--;
        case (rx_mode)
            RX_OPEN: out_ready <= 1'b1;
            RX_COIN: out_ready <= $urandom_range(0, 1);
            default: out_ready <= 1'b0;
        endcase
    end

    function automatic logic signed [SAMPLE_W-1:0] gen_sample(pattern_t pat);
        int unsigned                r;
        int unsigned                c;
        logic signed [SAMPLE_W-1:0] v;
        r = sb.row_cnt;
        c = sb.col_cnt;
        case (pat)
            PAT_SMALL:   v = SAMPLE_W'($urandom_range(0, 16)) - 16'sd8;
            PAT_EXTREME: v = $urandom_range(0, 1) ? S_MAX : S_MIN;
            PAT_FLAT:    v = k1;
            PAT_CHECKER: v = ((r + c) % 2 == 0) ? k1 : k2;
            PAT_COLUMN:  v = k1 + SAMPLE_W'(c) * k2;   // a stays zero
            PAT_ROW:     v = k1 + SAMPLE_W'(r) * k2;   // b stays zero
            default:     v = SAMPLE_W'($urandom);
        endcase
        // occasional noise so structured planes still see odd corners
        if (pat != PAT_RANDOM && $urandom_range(0, 19) == 0)
            v = SAMPLE_W'($urandom);
        return v;
    endfunction

    task automatic send_sample(pattern_t pat, logic signed [SAMPLE_W-1:0] fixed_val);
        @(negedge clk);
        in_valid <= 1'b1;
        potential <= (pat == PAT_DIRECT) ? fixed_val : gen_sample(pat);
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
    endtask

    task automatic pause_sender(int unsigned cycles);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // wait until every expected cell has come back and the block is quiet
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.expected_cells.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_settings(logic [CFG_DATA_W-1:0] h, logic [CFG_DATA_W-1:0] w,
                                  logic [SPACING_W-1:0] s, logic [2:0] mask,
                                  bit poke_unused);
        if (mask[0])
            write_reg(REG_HEIGHT, h);
        if (mask[1])
            write_reg(REG_WIDTH, w);
        // upper data bits are don't-care for spacing
        if (mask[2])
            write_reg(REG_SPACING, {3'($urandom), s});
        if (poke_unused)
            write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        if (mask != 0)
            settings_used++;
    endtask

    task automatic run_phase(int unsigned n, pattern_t pat, bit bursty);
        int unsigned burst;
        burst = $urandom_range(1, 32);
        k1 = SAMPLE_W'($urandom);
        k2 = SAMPLE_W'($urandom);
        for (int unsigned i = 0; i < n; i++) begin
            send_sample(pat, '0);
            burst--;
            if (burst == 0) begin
                burst = $urandom_range(1, 32);
                if (bursty)
                    pause_sender(($urandom_range(0, 19) == 0) ? $urandom_range(20, 80)
                                                              : $urandom_range(1, 6));
            end
        end
        settle();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim(bit tall);
        case ($urandom_range(0, 19))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return tall ? 11'd2047 : 11'd2;
            3:       return tall ? 11'd1024 : 11'd3;
            4, 5, 6, 7, 8, 9:
                     return CFG_DATA_W'($urandom_range(2, 4));
            default: return CFG_DATA_W'($urandom_range(2, tall ? 14 : 16));
        endcase
    endfunction

    function automatic logic [SPACING_W-1:0] pick_spacing();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd255;
            default: return SPACING_W'($urandom);
        endcase
    endfunction

    initial begin
        int unsigned random_items;
        int unsigned n;
        sb = new();
        random_items = 0;

        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: 2x2 grid, spacing 1
        foreach (DIRECTED[i])
            send_sample(PAT_DIRECT, DIRECTED[i]);
        settle();

        // register extremes, sizes below range clamp up and zero spacing acts as 1
        apply_settings(11'd0, 11'd1, 8'd0, 3'b111, 1'b0);
        run_phase(40, PAT_RANDOM, 1'b1);
        apply_settings(11'd2047, 11'd3, 8'd255, 3'b111, 1'b0);
        run_phase(60, PAT_EXTREME, 1'b1);
        // oversized width clamps to the line buffer: one full row and some more
        apply_settings(11'd2, 11'd2047, 8'd1, 3'b111, 1'b1);
        run_phase(MAX_WIDTH + 60, PAT_RANDOM, 1'b1);
        apply_settings(11'd1024, 11'd1024, 8'd128, 3'b111, 1'b0);
        run_phase(20, PAT_SMALL, 1'b0);

        while (random_items < RANDOM_ITEMS) begin
            apply_settings(pick_dim(1'b1), pick_dim(1'b0), pick_spacing(),
                           3'($urandom_range(0, 7)), $urandom_range(0, 4) == 0);
            n = sb.eff_height() * sb.eff_width() * $urandom_range(1, 3);
            if (n > 150)
                n = $urandom_range(100, 150);
            n += $urandom_range(0, 7);
            run_phase(n, pattern_t'($urandom_range(PAT_RANDOM, PAT_ROW)),
                      $urandom_range(0, 9) >= 3);
            random_items += n;
        end

        if (sb.expected_cells.size() != 0)
            sb.report($sformatf("%0d expected cells never came",
                                sb.expected_cells.size()));
        $display("checked %0d cells (%0d zero vectors) from %0d samples", sb.cells_checked,
                 sb.zero_cells, samples_sent);
        $display("%0d register settings, grids from 2x2 to a full 1024-sample row",
                 settings_used);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d cells pending", sb.expected_cells.size());
        $display("FAILURE");
        $finish;
    end

endmodule
